// ===== hdl/wsfd_pkg.sv =====
// ----------------------------------------------------------------------------
// wsfd_pkg
// Shared types and constants of the WebSocket frame decoder.
// ----------------------------------------------------------------------------
package wsfd_pkg;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [6:0] LEN_CODE_EXT16 = 7'd126;
  localparam logic [6:0] LEN_CODE_EXT64 = 7'd127;
  localparam logic [3:0] EXT16_BYTES    = 4'd2;
  localparam logic [3:0] EXT64_BYTES    = 4'd8;
  localparam logic [3:0] KEY_BYTES      = 4'd4;

  typedef enum logic [2:0] {
    PH_HDR1   = 3'd0,
    PH_HDR2   = 3'd1,
    PH_EXTLEN = 3'd2,
    PH_KEY    = 3'd3,
    PH_DATA   = 3'd4
  } phase_t;

  // fin, rsv1..3, opcode, mask
  typedef struct packed {
    logic       fin;
    logic       rsv1;
    logic       rsv2;
    logic       rsv3;
    logic [3:0] opcode;
    logic       mask;
  } hdr_flags_t;

  // one queued result: raw byte and the key byte still to be applied
  typedef struct packed {
    logic        is_header;
    hdr_flags_t  flags;
    logic [63:0] length;
    logic [7:0]  raw_byte;
    logic [7:0]  key_byte;
    logic        frame_end;
  } result_t;

endpackage

// ===== hdl/wsfd_parse.sv =====
// ----------------------------------------------------------------------------
// wsfd_parse
// Front part: accepts stream bytes, tracks the frame phase and queues results.
// ----------------------------------------------------------------------------
module wsfd_parse (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         rx_byte,
  input  logic               q_full,
  output logic               push,
  output wsfd_pkg::result_t  push_data
);

  wsfd_pkg::phase_t     phase;
  wsfd_pkg::phase_t     phase_next;
  logic [3:0]           ext_len_count;
  logic [3:0]           ext_len_count_next;
  logic [63:0]          length_accum;
  logic [63:0]          length_accum_next;
  logic [63:0]          bytes_remaining;
  logic [63:0]          bytes_remaining_next;
  logic [31:0]          mask_key;
  logic [31:0]          mask_key_next;
  logic [1:0]           key_position;
  logic [1:0]           key_position_next;
  wsfd_pkg::hdr_flags_t header_flags;
  wsfd_pkg::hdr_flags_t header_flags_next;

  logic        accept;
  logic [6:0]  len_code;
  logic [3:0]  count_dec;
  logic [63:0] ext_len_shift;
  logic        last_byte;
  logic        len_zero_code;
  logic        len_zero_ext;
  logic        len_zero_key;
  logic [7:0]  cur_key_byte;

  assign in_stall      = q_full;
  assign accept        = in_valid && !q_full;
  assign len_code      = rx_byte[6:0];
  assign count_dec     = ext_len_count - 4'd1;
  assign ext_len_shift = {length_accum[55:0], rx_byte};
  assign last_byte     = (bytes_remaining[63:1] == 63'd0);
  assign len_zero_code = (len_code == 7'd0);
  assign len_zero_ext  = (ext_len_shift == 64'd0);
  assign len_zero_key  = (length_accum == 64'd0);
  assign cur_key_byte  = mask_key[(2'd3 - key_position) * 8 +: 8];

  // next phase
  always_comb begin
    phase_next = phase;
    if (accept) begin
      unique case (phase)
        wsfd_pkg::PH_HDR1: phase_next = wsfd_pkg::PH_HDR2;
        wsfd_pkg::PH_HDR2: begin
          if (len_code == wsfd_pkg::LEN_CODE_EXT16 || len_code == wsfd_pkg::LEN_CODE_EXT64)
            phase_next = wsfd_pkg::PH_EXTLEN;
          else if (rx_byte[7])
            phase_next = wsfd_pkg::PH_KEY;
          else if (len_zero_code)
            phase_next = wsfd_pkg::PH_HDR1;
          else
            phase_next = wsfd_pkg::PH_DATA;
        end
        wsfd_pkg::PH_EXTLEN: begin
          if (count_dec != 4'd0)
            phase_next = wsfd_pkg::PH_EXTLEN;
          else if (header_flags.mask)
            phase_next = wsfd_pkg::PH_KEY;
          else if (len_zero_ext)
            phase_next = wsfd_pkg::PH_HDR1;
          else
            phase_next = wsfd_pkg::PH_DATA;
        end
        wsfd_pkg::PH_KEY: begin
          if (count_dec != 4'd0)
            phase_next = wsfd_pkg::PH_KEY;
          else if (len_zero_key)
            phase_next = wsfd_pkg::PH_HDR1;
          else
            phase_next = wsfd_pkg::PH_DATA;
        end
        wsfd_pkg::PH_DATA: begin
          if (last_byte)
            phase_next = wsfd_pkg::PH_HDR1;
        end
        default: phase_next = wsfd_pkg::PH_HDR1;
      endcase
    end
  end

  // datapath and queue push
  always_comb begin
    ext_len_count_next   = ext_len_count;
    length_accum_next    = length_accum;
    bytes_remaining_next = bytes_remaining;
    mask_key_next        = mask_key;
    key_position_next    = key_position;
    header_flags_next    = header_flags;
    push                 = 1'b0;
    push_data            = '0;
    if (accept) begin
      unique case (phase)
        wsfd_pkg::PH_HDR1: begin
          header_flags_next.fin    = rx_byte[7];
          header_flags_next.rsv1   = rx_byte[6];
          header_flags_next.rsv2   = rx_byte[5];
          header_flags_next.rsv3   = rx_byte[4];
          header_flags_next.opcode = rx_byte[3:0];
          header_flags_next.mask   = 1'b0;
          length_accum_next        = 64'd0;
        end
        wsfd_pkg::PH_HDR2: begin
          header_flags_next.mask = rx_byte[7];
          if (len_code == wsfd_pkg::LEN_CODE_EXT16) begin
            length_accum_next  = 64'd0;
            ext_len_count_next = wsfd_pkg::EXT16_BYTES;
          end else if (len_code == wsfd_pkg::LEN_CODE_EXT64) begin
            length_accum_next  = 64'd0;
            ext_len_count_next = wsfd_pkg::EXT64_BYTES;
          end else begin
            length_accum_next = {57'd0, len_code};
            mask_key_next     = 32'd0;
            if (rx_byte[7]) begin
              ext_len_count_next = wsfd_pkg::KEY_BYTES;
            end else begin
              bytes_remaining_next = {57'd0, len_code};
              key_position_next    = 2'd0;
              push                 = 1'b1;
              push_data.is_header  = 1'b1;
              push_data.flags      = header_flags_next;
              push_data.length     = {57'd0, len_code};
              push_data.frame_end  = len_zero_code;
            end
          end
        end
        wsfd_pkg::PH_EXTLEN: begin
          length_accum_next  = ext_len_shift;
          ext_len_count_next = count_dec;
          if (count_dec == 4'd0) begin
            mask_key_next = 32'd0;
            if (header_flags.mask) begin
              ext_len_count_next = wsfd_pkg::KEY_BYTES;
            end else begin
              bytes_remaining_next = ext_len_shift;
              key_position_next    = 2'd0;
              push                 = 1'b1;
              push_data.is_header  = 1'b1;
              push_data.flags      = header_flags;
              push_data.length     = ext_len_shift;
              push_data.frame_end  = len_zero_ext;
            end
          end
        end
        wsfd_pkg::PH_KEY: begin
          mask_key_next      = {mask_key[23:0], rx_byte};
          ext_len_count_next = count_dec;
          if (count_dec == 4'd0) begin
            bytes_remaining_next = length_accum;
            key_position_next    = 2'd0;
            push                 = 1'b1;
            push_data.is_header  = 1'b1;
            push_data.flags      = header_flags;
            push_data.length     = length_accum;
            push_data.frame_end  = len_zero_key;
          end
        end
        wsfd_pkg::PH_DATA: begin
          key_position_next    = key_position + 2'd1;
          bytes_remaining_next = last_byte ? 64'd0 : bytes_remaining - 64'd1;
          push                 = 1'b1;
          push_data.flags      = header_flags;
          push_data.length     = length_accum;
          push_data.raw_byte   = rx_byte;
          push_data.key_byte   = header_flags.mask ? cur_key_byte : 8'd0;
          push_data.frame_end  = last_byte;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= wsfd_pkg::PH_HDR1;
      ext_len_count   <= 4'd0;
      length_accum    <= 64'd0;
      bytes_remaining <= 64'd0;
      mask_key        <= 32'd0;
      key_position    <= 2'd0;
      header_flags    <= '0;
    end else begin
      phase           <= phase_next;
      ext_len_count   <= ext_len_count_next;
      length_accum    <= length_accum_next;
      bytes_remaining <= bytes_remaining_next;
      mask_key        <= mask_key_next;
      key_position    <= key_position_next;
      header_flags    <= header_flags_next;
    end
  end

endmodule

// ===== hdl/wsfd_queue.sv =====
// ----------------------------------------------------------------------------
// wsfd_queue
// Short result queue between the parser and the output stage.
// ----------------------------------------------------------------------------
module wsfd_queue #(
  parameter int DEPTH = wsfd_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  wsfd_pkg::result_t  push_data,
  input  logic               pop,
  output wsfd_pkg::result_t  pop_data,
  output logic               empty,
  output logic               full
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  wsfd_pkg::result_t entries [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;

  assign empty    = (count == '0);
  assign full     = (count == CNT_FULL);
  assign pop_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push)
      entries[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push)
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + PTR_W'(1);
      if (pop)
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + PTR_W'(1);
      if (push && !pop)
        count <= count + CNT_W'(1);
      else if (pop && !push)
        count <= count - CNT_W'(1);
    end
  end

endmodule

// ===== hdl/wsfd_emit.sv =====
// ----------------------------------------------------------------------------
// wsfd_emit
// Back part: unmasks payload bytes and holds the registered result.
// ----------------------------------------------------------------------------
module wsfd_emit (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_empty,
  input  wsfd_pkg::result_t  q_data,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               is_header,
  output logic               fin,
  output logic               rsv1,
  output logic               rsv2,
  output logic               rsv3,
  output logic [3:0]         frame_opcode,
  output logic               masked,
  output logic [63:0]        frame_length,
  output logic [7:0]         data_byte,
  output logic               frame_end
);

  assign pop = !q_empty && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst)
      out_valid <= 1'b0;
    else if (!out_valid || !out_stall)
      out_valid <= !q_empty;
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      is_header    <= q_data.is_header;
      fin          <= q_data.flags.fin;
      rsv1         <= q_data.flags.rsv1;
      rsv2         <= q_data.flags.rsv2;
      rsv3         <= q_data.flags.rsv3;
      frame_opcode <= q_data.flags.opcode;
      masked       <= q_data.flags.mask;
      frame_length <= q_data.length;
      data_byte    <= q_data.raw_byte ^ q_data.key_byte;
      frame_end    <= q_data.frame_end;
    end
  end

endmodule

// ===== hdl/websocket_frame_decoder.sv =====
// ----------------------------------------------------------------------------
// websocket_frame_decoder
// Parses a WebSocket byte stream into header and unmasked payload results.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-------------------------------
//   in      | to block  | in_valid / in_stall  | rx_byte
//   out     | from block| out_valid / out_stall| is_header .. frame_end
//
// One byte is taken per cycle while in_stall is low; each payload byte and each
// completed header gives one result that shows on the outputs after passing
// through the result queue and the output register. Header bytes before
// completion give no result.
// Reset clears the parse phase, the queue and the output valid.
// in_stall is the result queue's full flag; the queue fills while out_stall holds.
// ----------------------------------------------------------------------------
module websocket_frame_decoder #(
  parameter int QUEUE_DEPTH = wsfd_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        is_header,
  output logic        fin,
  output logic        rsv1,
  output logic        rsv2,
  output logic        rsv3,
  output logic [3:0]  frame_opcode,
  output logic        masked,
  output logic [63:0] frame_length,
  output logic [7:0]  data_byte,
  output logic        frame_end
);

  logic              push;
  wsfd_pkg::result_t push_data;
  logic              pop;
  wsfd_pkg::result_t pop_data;
  logic              q_empty;
  logic              q_full;

  wsfd_parse u_parse (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .rx_byte   (rx_byte),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  wsfd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (q_empty),
    .full      (q_full)
  );

  wsfd_emit u_emit (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_empty),
    .q_data       (pop_data),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .is_header    (is_header),
    .fin          (fin),
    .rsv1         (rsv1),
    .rsv2         (rsv2),
    .rsv3         (rsv3),
    .frame_opcode (frame_opcode),
    .masked       (masked),
    .frame_length (frame_length),
    .data_byte    (data_byte),
    .frame_end    (frame_end)
  );

endmodule

// ===== sim/websocket_frame_decoder_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// websocket_frame_decoder_tb
// Drives a WebSocket byte stream into the frame decoder with random idle
// cycles on both channels and checks each header and payload result against the
// table's expectation or an in-bench decoder. A short table of hand-made frames
// comes first, then random frames of all three length forms, masked and
// unmasked, and at the end an open frame with an all-ones 64-bit length.
// ----------------------------------------------------------------------------
module websocket_frame_decoder_tb;

  localparam int DIR_ROWS       = 26;
  localparam int RANDOM_BYTES   = 850;
  localparam int RESET_CYCLES   = 6;
  localparam int QUIET_FROM     = 350;
  localparam int QUIET_TO       = 550;
  localparam int DRAIN_CYCLES   = 8;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_REPORTS    = 10;

  typedef enum {LEN_SHORT, LEN_16, LEN_64} len_form_t;

  typedef struct packed {
    logic        is_header;
    logic        fin;
    logic        rsv1;
    logic        rsv2;
    logic        rsv3;
    logic [3:0]  opcode;
    logic        masked;
    logic [63:0] length;
    logic [7:0]  data;
    logic        frame_end;
  } frame_result_t;

  typedef struct {
    logic [7:0]    rx;
    bit            has_exp;
    frame_result_t exp;
  } stim_row_t;

  localparam frame_result_t NO_RESULT = '0;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  rx_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        is_header;
  logic        fin;
  logic        rsv1;
  logic        rsv2;
  logic        rsv3;
  logic [3:0]  frame_opcode;
  logic        masked;
  logic [63:0] frame_length;
  logic [7:0]  data_byte;
  logic        frame_end;

  stim_row_t     dir_table [DIR_ROWS];
  stim_row_t     stim_q [$];
  frame_result_t pending_results [$];

  int feed_idx      = 0;
  int take_idx      = 0;
  int idle_cycles   = 0;
  int mismatches    = 0;
  int header_count  = 0;
  int payload_count = 0;
  int frame_total   = 0;

  // decoder state
  wsfd_pkg::phase_t     dec_phase   = wsfd_pkg::PH_HDR1;
  logic [3:0]           dec_count   = '0;
  logic [63:0]          dec_len     = '0;
  logic [63:0]          dec_left    = '0;
  logic [31:0]          dec_key     = '0;
  logic [1:0]           dec_key_pos = '0;
  wsfd_pkg::hdr_flags_t dec_flags   = '0;

  wire gaps_on = !(feed_idx >= QUIET_FROM && feed_idx < QUIET_TO);

  websocket_frame_decoder u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .rx_byte      (rx_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .is_header    (is_header),
    .fin          (fin),
    .rsv1         (rsv1),
    .rsv2         (rsv2),
    .rsv3         (rsv3),
    .frame_opcode (frame_opcode),
    .masked       (masked),
    .frame_length (frame_length),
    .data_byte    (data_byte),
    .frame_end    (frame_end)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic frame_result_t frame_result(logic hdr, logic [7:0] data, logic last);
    return {hdr, dec_flags.fin, dec_flags.rsv1, dec_flags.rsv2, dec_flags.rsv3,
            dec_flags.opcode, dec_flags.mask, dec_len, data, last};
  endfunction

  function automatic frame_result_t close_header();
    dec_left    = dec_len;
    dec_key_pos = '0;
    dec_phase   = (dec_len == 64'd0) ? wsfd_pkg::PH_HDR1 : wsfd_pkg::PH_DATA;
    return frame_result(1'b1, 8'h00, dec_len == 64'd0);
  endfunction

  function automatic bit length_known(output frame_result_t res);
    res     = '0;
    dec_key = '0;
    if (dec_flags.mask) begin
      dec_count = wsfd_pkg::KEY_BYTES;
      dec_phase = wsfd_pkg::PH_KEY;
      return 1'b0;
    end
    res = close_header();
    return 1'b1;
  endfunction

  function automatic bit decode_rx(input logic [7:0] b, output frame_result_t res);
    logic       last;
    logic [7:0] d;
    res = '0;
    case (dec_phase)
      wsfd_pkg::PH_HDR1: begin
        dec_flags = '{fin: b[7], rsv1: b[6], rsv2: b[5], rsv3: b[4],
                      opcode: b[3:0], mask: 1'b0};
        dec_len   = '0;
        dec_phase = wsfd_pkg::PH_HDR2;
        return 1'b0;
      end
      wsfd_pkg::PH_HDR2: begin
        dec_flags.mask = b[7];
        if (b[6:0] == wsfd_pkg::LEN_CODE_EXT16 || b[6:0] == wsfd_pkg::LEN_CODE_EXT64) begin
          dec_len   = '0;
          dec_count = (b[6:0] == wsfd_pkg::LEN_CODE_EXT16) ? wsfd_pkg::EXT16_BYTES
                                                           : wsfd_pkg::EXT64_BYTES;
          dec_phase = wsfd_pkg::PH_EXTLEN;
          return 1'b0;
        end
        dec_len = {57'd0, b[6:0]};
        return length_known(res);
      end
      wsfd_pkg::PH_EXTLEN: begin
        dec_len   = {dec_len[55:0], b};
        dec_count = dec_count - 4'd1;
        if (dec_count != 4'd0) return 1'b0;
        return length_known(res);
      end
      wsfd_pkg::PH_KEY: begin
        dec_key   = {dec_key[23:0], b};
        dec_count = dec_count - 4'd1;
        if (dec_count != 4'd0) return 1'b0;
        res = close_header();
        return 1'b1;
      end
      wsfd_pkg::PH_DATA: begin
        last        = (dec_left <= 64'd1);
        d           = dec_flags.mask ? b ^ dec_key[8 * (3 - int'(dec_key_pos)) +: 8] : b;
        dec_key_pos = dec_key_pos + 2'd1;
        dec_left    = last ? 64'd0 : dec_left - 64'd1;
        res         = frame_result(1'b0, d, last);
        if (last) dec_phase = wsfd_pkg::PH_HDR1;
        return 1'b1;
      end
      default: begin
        dec_phase = wsfd_pkg::PH_HDR1;
        return 1'b0;
      end
    endcase
  endfunction

  function automatic string show(frame_result_t r);
    return $sformatf("hdr=%0b flags=%b op=%h mask=%0b len=%h data=%h end=%0b",
                     r.is_header, {r.fin, r.rsv1, r.rsv2, r.rsv3}, r.opcode,
                     r.masked, r.length, r.data, r.frame_end);
  endfunction

  function automatic void push_rx(logic [7:0] b);
    stim_q.insert(stim_q.size(), '{rx: b, has_exp: 1'b0, exp: NO_RESULT});
  endfunction

  function automatic void queue_frame(logic [7:0] b1, logic m, len_form_t form,
                                      logic [63:0] len, int data_count);
    logic [6:0] code;
    push_rx(b1);
    case (form)
      LEN_16:  code = wsfd_pkg::LEN_CODE_EXT16;
      LEN_64:  code = wsfd_pkg::LEN_CODE_EXT64;
      default: code = len[6:0];
    endcase
    push_rx({m, code});
    if (form == LEN_16) for (int i = 1; i >= 0; i--) push_rx(len[8 * i +: 8]);
    if (form == LEN_64) for (int i = 7; i >= 0; i--) push_rx(len[8 * i +: 8]);
    if (m) repeat (4) push_rx(8'($urandom));
    repeat (data_count) push_rx(8'($urandom));
  endfunction

  // byte feeder
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (feed_idx < stim_q.size() && !(gaps_on && $urandom_range(0, 99) < 6)) begin
        in_valid <= 1'b1;
        rx_byte  <= stim_q[feed_idx].rx;
        feed_idx <= feed_idx + 1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= gaps_on && ($urandom_range(0, 99) < 6);
    end
  end

  // predict on each input transfer, check on each output transfer
  always @(posedge clk) begin
    frame_result_t pred;
    frame_result_t want;
    frame_result_t seen;
    bit            got;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        got = decode_rx(rx_byte, pred);
        if (stim_q[take_idx].has_exp) begin
          pending_results.insert(pending_results.size(), stim_q[take_idx].exp);
        end else if (got) begin
          pending_results.insert(pending_results.size(), pred);
        end
        take_idx <= take_idx + 1;
      end
      if (out_valid && !out_stall) begin
        seen = {is_header, fin, rsv1, rsv2, rsv3, frame_opcode, masked,
                frame_length, data_byte, frame_end};
        if (pending_results.size() == 0) begin
          if (mismatches < MAX_REPORTS) $display("%0t: unexpected result %s", $time, show(seen));
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          if (seen !== want) begin
            if (mismatches < MAX_REPORTS) begin
              $display("%0t: mismatch exp %s", $time, show(want));
              $display("%0t:          got %s", $time, show(seen));
            end
            mismatches++;
          end
          if (seen.is_header) header_count++;
          else payload_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles == WATCHDOG_LIMIT) begin
        $display("FAIL websocket_frame_decoder");
        $finish;
      end
    end
  end

  initial begin
    int          pick;
    len_form_t   form;
    logic [63:0] len;
    dir_table = '{
      '{8'hFF, 1'b0, NO_RESULT},
      '{8'h00, 1'b1, {1'b1, 4'hF, 4'hF, 1'b0, 64'd0, 8'h00, 1'b1}},
      '{8'h00, 1'b0, NO_RESULT},
      '{8'h81, 1'b0, NO_RESULT},
      '{8'hA5, 1'b0, NO_RESULT},
      '{8'h5A, 1'b0, NO_RESULT},
      '{8'hFF, 1'b0, NO_RESULT},
      '{8'h00, 1'b1, {1'b1, 4'h0, 4'h0, 1'b1, 64'd1, 8'h00, 1'b0}},
      '{8'hFF, 1'b1, {1'b0, 4'h0, 4'h0, 1'b1, 64'd1, 8'h5A, 1'b1}},
      '{8'h82, 1'b0, NO_RESULT},
      '{8'h7E, 1'b0, NO_RESULT},
      '{8'h00, 1'b0, NO_RESULT},
      '{8'h02, 1'b1, {1'b1, 4'h8, 4'h2, 1'b0, 64'd2, 8'h00, 1'b0}},
      '{8'h00, 1'b1, {1'b0, 4'h8, 4'h2, 1'b0, 64'd2, 8'h00, 1'b0}},
      '{8'hFF, 1'b1, {1'b0, 4'h8, 4'h2, 1'b0, 64'd2, 8'hFF, 1'b1}},
      '{8'h3A, 1'b0, NO_RESULT},
      '{8'h7F, 1'b0, NO_RESULT},
      '{8'h00, 1'b0, NO_RESULT},
      '{8'h00, 1'b0, NO_RESULT},
      '{8'h00, 1'b0, NO_RESULT},
      '{8'h00, 1'b0, NO_RESULT},
      '{8'h00, 1'b0, NO_RESULT},
      '{8'h00, 1'b0, NO_RESULT},
      '{8'h00, 1'b0, NO_RESULT},
      '{8'h01, 1'b1, {1'b1, 4'h3, 4'hA, 1'b0, 64'd1, 8'h00, 1'b0}},
      '{8'h7E, 1'b1, {1'b0, 4'h3, 4'hA, 1'b0, 64'd1, 8'h7E, 1'b1}}
    };
    foreach (dir_table[i]) stim_q.insert(stim_q.size(), dir_table[i]);
    frame_total = 4;

    while (stim_q.size() < DIR_ROWS + RANDOM_BYTES) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        form = LEN_SHORT;
        pick = $urandom_range(0, 19);
        if (pick == 0) len = 64'd125;
        else if (pick < 3) len = 64'($urandom_range(0, 125));
        else len = 64'($urandom_range(0, 8));
      end else if (pick < 82) begin
        form = LEN_16;
        len  = ($urandom_range(0, 9) == 0) ? 64'($urandom_range(126, 300))
                                           : 64'($urandom_range(0, 20));
      end else begin
        form = LEN_64;
        len  = 64'($urandom_range(0, 20));
      end
      queue_frame(8'($urandom), 1'($urandom), form, len, int'(len));
      frame_total++;
    end
    // open frame with the largest length, left unfinished
    queue_frame({1'b1, 7'($urandom)}, 1'b1, LEN_64, '1, 6);
    frame_total++;

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    wait (take_idx == stim_q.size());
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d bytes in %0d frames (short, 16-bit and 64-bit lengths, masked and plain)",
             stim_q.size(), frame_total);
    $display("Checked %0d header and %0d payload results, %0d mismatches",
             header_count, payload_count, mismatches);
    if (mismatches == 0) begin
      $display("PASS websocket_frame_decoder");
    end else begin
      $display("FAIL websocket_frame_decoder");
    end
    $finish;
  end

endmodule
